// ----- design/skf_pkg.sv -----
package skf_pkg;

    // default sample width (signed Q4.28 at 32 bits)
    localparam int SAMPLE_WIDTH = 32;

    // Q2.30 helpers
    localparam int          FRAC_W  = 30;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // register reset values
    localparam logic [31:0] PNOISE_RST = 32'd1073742;
    localparam logic [31:0] MNOISE_RST = 32'd107374182;

    // register indexes
    localparam logic [1:0] REG_PNOISE = 2'd0;
    localparam logic [1:0] REG_MNOISE = 2'd1;
    localparam logic [1:0] REG_INIT   = 2'd2;

    // gain divider: one quotient bit per step, gain is at most 1.0
    localparam int DIV_STEPS = FRAC_W + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = FRAC_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // wide view of the error magnitude, split into hi and lo parts
    localparam int WIDE_W = 64;

endpackage

// ----- design/scalar_kalman_filter.sv -----
// channel      | direction | signals                                         | payload
// -------------+-----------+-------------------------------------------------+---------------
// measurement  | in        | i_valid / o_ready                               | i_measurement
// estimate     | out       | o_valid / i_ready                               | o_estimate
// config       | in        | psel, penable, pwrite, paddr, pwdata, prdata    | q, r, x0
//
// one request runs through a prepare step, a restoring divider for the gain
// (one quotient bit each step), 3 passes through the shared 32x31 multiplier
// and an update step; o_ready returns in the cycle after the update, so a
// new measurement is taken only once the previous request has finished
// the update cycle stalls while an untaken estimate sits in the output register
// reset is synchronous and active low; it restores q, r, x0 and the state
module scalar_kalman_filter #(
    parameter int SAMPLE_WIDTH = skf_pkg::SAMPLE_WIDTH,
    parameter int DATA_W       = (SAMPLE_WIDTH > 32) ? 64 : 32,
    parameter int ADDR_W       = (SAMPLE_WIDTH > 32) ? 5 : 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // measurement request
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [SAMPLE_WIDTH-1:0] i_measurement,
    // estimate request
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [SAMPLE_WIDTH-1:0] o_estimate,
    // register port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int IDX_LSB = ADDR_W - 2;   // byte stride 4 or 8

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,   // waiting for a measurement
        S_PREP = 7'b0000010,   // denominator and error
        S_DIV  = 7'b0000100,   // gain, one bit a cycle
        S_MLO  = 7'b0001000,   // lo part of error times gain
        S_MHI  = 7'b0010000,   // hi part of error times gain
        S_MCV  = 7'b0100000,   // (1 - gain) times predicted covariance
        S_UPD  = 7'b1000000    // commit state and load the output
    } t_state;

    t_state r_state, n_state;

    // configuration and filter state
    logic [31:0]   r_q;
    logic [31:0]   r_r;
    logic [SW-1:0] r_x0;
    logic [SW-1:0] r_x;        // current estimate
    logic [31:0]   r_p;        // error covariance

    // working registers
    logic [SW-1:0]              r_z;
    logic [31:0]                r_pp;       // predicted covariance
    logic [32:0]                r_den;      // pp + r, exact
    logic                       r_den_zero;
    logic [33:0]                r_rem;      // divider remainder
    logic [skf_pkg::MUL_B_W-1:0] r_k;       // gain, Q.30, at most 1.0
    logic [skf_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_neg;      // sign of z - x
    logic [SW:0]                r_mag;      // |z - x|
    logic [skf_pkg::PROD_W-1:0] r_prod;     // registered multiplier output
    logic [32:0]                r_lo_corr;  // rounded lo contribution
    logic [SW:0]                r_corr;     // rounded correction magnitude

    // output register
    logic          r_o_valid;
    logic [SW-1:0] r_o_est;

    // request handshakes
    logic in_acc;
    logic out_free;
    logic cfg_wr;
    logic [1:0] cfg_idx;

    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid & o_ready;
    assign out_free = ~r_o_valid | i_ready;
    assign o_valid  = r_o_valid;
    assign o_estimate = r_o_est;
    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = paddr[ADDR_W-1:IDX_LSB];

    // predicted covariance, saturating at the top of Q2.30
    logic [32:0] pp_sum;
    logic [31:0] pp_sat;
    assign pp_sum = {1'b0, r_p} + {1'b0, r_q};
    assign pp_sat = pp_sum[32] ? '1 : pp_sum[31:0];

    // innovation z - x, one bit wider so it is exact
    logic signed [SW:0] diff;
    assign diff = $signed({r_z[SW-1], r_z}) - $signed({r_x[SW-1], r_x});

    // divider step: compare, subtract, shift
    logic        div_ge;
    logic [33:0] div_sub;
    assign div_ge  = (r_rem >= {1'b0, r_den});
    assign div_sub = div_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    // error magnitude split at the binary point of the gain
    logic [skf_pkg::WIDE_W-1:0] mag_w;
    logic [29:0]                mag_lo;
    logic [31:0]                mag_hi;
    assign mag_w  = skf_pkg::WIDE_W'(r_mag);
    assign mag_lo = mag_w[29:0];
    assign mag_hi = mag_w[61:30];

    // shared multiplier, operands picked by the sequencer
    logic [skf_pkg::MUL_A_W-1:0] mul_a;
    logic [skf_pkg::MUL_B_W-1:0] mul_b;
    logic [skf_pkg::PROD_W-1:0]  mul_p;

    always_comb begin
        case (r_state)
            S_MLO: begin
                mul_a = {2'b00, mag_lo};
                mul_b = r_k;
            end
            S_MHI: begin
                mul_a = mag_hi;
                mul_b = r_k;
            end
            S_MCV: begin
                mul_a = r_pp;
                // 1.0 - gain, gain never exceeds 1.0
                mul_b = skf_pkg::MUL_B_W'(skf_pkg::ONE_Q30) - r_k;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = skf_pkg::PROD_W'(mul_a) * skf_pkg::PROD_W'(mul_b);

    // rounding constant, one half in Q.30
    localparam logic [skf_pkg::PROD_W-1:0] HALF = skf_pkg::PROD_W'(1) << (skf_pkg::FRAC_W - 1);

    logic [skf_pkg::PROD_W-1:0] lo_rnd;
    logic [skf_pkg::PROD_W-1:0] corr_sum;
    logic [skf_pkg::PROD_W-1:0] p_rnd;
    assign lo_rnd   = r_prod + HALF;
    assign corr_sum = r_prod + skf_pkg::PROD_W'(r_lo_corr);
    assign p_rnd    = r_prod + HALF;

    // estimate moves toward z by the correction; the result stays between x and z
    logic [SW:0] x_ext;
    logic [SW:0] x_upd;
    assign x_ext = {r_x[SW-1], r_x};
    assign x_upd = r_neg ? (x_ext - r_corr) : (x_ext + r_corr);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) begin
                n_state = S_PREP;
            end
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (r_cnt == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
                n_state = S_MLO;
            end
            S_MLO:   n_state = S_MHI;
            S_MHI:   n_state = S_MCV;
            S_MCV:   n_state = S_UPD;
            S_UPD:   if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_q       <= skf_pkg::PNOISE_RST;
            r_r       <= skf_pkg::MNOISE_RST;
            r_x0      <= '0;
            r_x       <= '0;
            r_p       <= skf_pkg::ONE_Q30;
        end else begin
            r_state <= n_state;

            // estimate loaded on update, cleared once taken downstream
            if (r_state == S_UPD && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_z  <= i_measurement;
                        r_pp <= pp_sat;
                    end
                end
                S_PREP: begin
                    r_den      <= {1'b0, r_pp} + {1'b0, r_r};
                    r_den_zero <= (r_pp == '0) && (r_r == '0);
                    r_rem      <= {2'b00, r_pp};
                    r_k        <= '0;
                    r_cnt      <= '0;
                    r_neg      <= diff[SW];
                    r_mag      <= diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);
                end
                S_DIV: begin
                    r_rem <= {div_sub[32:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    // zero denominator gives zero gain
                    if (r_cnt == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1) && r_den_zero) begin
                        r_k <= '0;
                    end else begin
                        r_k <= {r_k[skf_pkg::MUL_B_W-2:0], div_ge};
                    end
                end
                S_MLO: begin
                    r_prod <= mul_p;
                end
                S_MHI: begin
                    r_prod    <= mul_p;
                    r_lo_corr <= lo_rnd[62:30];
                end
                S_MCV: begin
                    r_prod <= mul_p;
                    r_corr <= corr_sum[SW:0];
                end
                S_UPD: begin
                    if (out_free) begin
                        r_x     <= x_upd[SW-1:0];
                        r_p     <= p_rnd[61:30];
                        r_o_est <= x_upd[SW-1:0];
                    end
                end
                default: begin
                end
            endcase

            // register writes must arrive only while the filter is idle; the block itself does not enforce it
            if (cfg_wr) begin
                case (cfg_idx)
                    skf_pkg::REG_PNOISE: r_q <= pwdata[31:0];
                    skf_pkg::REG_MNOISE: r_r <= pwdata[31:0];
                    skf_pkg::REG_INIT: begin
                        r_x0 <= pwdata[SW-1:0];
                        r_x  <= pwdata[SW-1:0];
                        r_p  <= skf_pkg::ONE_Q30;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // register read back
    always_comb begin
        case (cfg_idx)
            skf_pkg::REG_PNOISE: prdata = DATA_W'(r_q);
            skf_pkg::REG_MNOISE: prdata = DATA_W'(r_r);
            skf_pkg::REG_INIT:   prdata = DATA_W'(r_x0);
            default:             prdata = '0;
        endcase
    end

endmodule

// ----- tb/scalar_kalman_filter_tb.sv -----
`timescale 1ns / 100ps

module scalar_kalman_filter_tb;

    // watchdog limit: cycles in a row with no handshake of any kind
    localparam int QUIET_LIMIT = 3000;
    // receiver hold-off, long enough to stall the measurement side
    localparam int HOLD_OFF_CYCLES = 250;
    // pause before register writes and at the end
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_PHASES = 8;
    // address 12 decodes to no register
    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN = 32'h8000_0000;

    // tracks filter state and the estimates still owed by the block
    class estimate_tracker;
        localparam logic [63:0] ONE_W  = {32'd0, skf_pkg::ONE_Q30};
        localparam logic [63:0] HALF_W = 64'h0000_0000_2000_0000;
        localparam logic [63:0] SAT_W  = 64'h0000_0000_FFFF_FFFF;

        logic [31:0] q_noise;
        logic [31:0] r_noise;
        logic [31:0] x_est;
        logic [31:0] p_cov;
        logic [31:0] expected_estimates[$];
        int errors;

        function new();
            q_noise = skf_pkg::PNOISE_RST;
            r_noise = skf_pkg::MNOISE_RST;
            x_est   = 32'd0;
            p_cov   = skf_pkg::ONE_Q30;
            errors  = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                skf_pkg::REG_PNOISE: q_noise = value;
                skf_pkg::REG_MNOISE: r_noise = value;
                skf_pkg::REG_INIT: begin
                    x_est = value;
                    p_cov = skf_pkg::ONE_Q30;
                end
                default: ;
            endcase
        endfunction

        // mag * k / 2^30 rounded to nearest, split to keep products in 64 bits
        function logic [63:0] scaled_round(logic [63:0] mag, logic [63:0] k);
            return (mag >> skf_pkg::FRAC_W) * k
                + ((((mag & (ONE_W - 1)) * k) + HALF_W) >> skf_pkg::FRAC_W);
        endfunction

        function void note_measurement(logic [31:0] z);
            logic [63:0] pp;
            logic [63:0] den;
            logic [63:0] gain;
            longint diff;
            longint x_wide;
            pp = {32'd0, p_cov} + {32'd0, q_noise};
            if (pp > SAT_W) pp = SAT_W;
            den = pp + {32'd0, r_noise};
            gain = (den == 64'd0) ? 64'd0 : (pp << skf_pkg::FRAC_W) / den;
            if (gain > ONE_W) gain = ONE_W;
            x_wide = longint'($signed(x_est));
            diff = longint'($signed(z)) - x_wide;
            if (diff >= 0) begin
                x_wide = x_wide + longint'(scaled_round(diff, gain));
            end else begin
                x_wide = x_wide - longint'(scaled_round(-diff, gain));
            end
            x_est = x_wide[31:0];
            p_cov = 32'((((ONE_W - gain) * pp) + HALF_W) >> skf_pkg::FRAC_W);
            expected_estimates = {expected_estimates, x_est};
        endfunction

        function void check_estimate(logic [31:0] got);
            logic [31:0] want;
            if (expected_estimates.size() == 0) begin
                $error("estimate: nothing expected, got %h", got);
                errors++;
            end else begin
                want = expected_estimates.pop_front();
                if (got !== want) begin
                    $error("estimate: expected %h, got %h", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_valid;
    logic                             o_ready;
    logic [skf_pkg::SAMPLE_WIDTH-1:0] i_measurement;
    logic                             o_valid;
    logic                             i_ready;
    logic [skf_pkg::SAMPLE_WIDTH-1:0] o_estimate;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [3:0]                       paddr;
    logic [31:0]                      pwdata;
    logic [31:0]                      prdata;
    logic                             pready;

    estimate_tracker tracker = new();
    // no idling on either side while set
    bit steady = 1'b0;
    // asks the receiver for one long hold-off
    bit hold_off_req = 1'b0;

    scalar_kalman_filter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_measurement (i_measurement),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_estimate    (o_estimate),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // setup cycle, then access cycle; the register takes the value when pready is seen
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tracker.write_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // idle cycle so a following write starts in a fresh step
        @(posedge i_clk);
    endtask

    // offer one measurement request, sometimes after a gap, and hold it until taken
    task automatic send_measurement(input logic [31:0] z);
        if (!steady && $urandom_range(0, 99) < 35) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_measurement <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.note_measurement(z);
    endtask

    // block idle: every estimate back, then the settle pause
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (tracker.expected_estimates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // half noisy readings around a phase target, some extremes, the rest anything
    function automatic logic [31:0] pick_measurement(logic [31:0] target);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return target + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        if (roll < 60) begin
            case ($urandom_range(0, 3))
                0: return S_MAX;
                1: return S_MIN;
                2: return 32'd0;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h000F_FFFF);
            3: return $urandom_range(0, skf_pkg::ONE_Q30);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_start();
        case ($urandom_range(0, 3))
            0: return S_MAX;
            1: return S_MIN;
            default: return $urandom();
        endcase
    endfunction

    // stimulus
    initial begin
        int n_items;
        logic [31:0] target;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_measurement <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values of q and r, estimate starts at zero
        send_measurement(32'd0);
        send_measurement(S_MAX);
        send_measurement(S_MIN);
        send_measurement(32'h1000_0000);

        // zero noise: gain of one snaps to the reading, then zero denominator holds it
        wait_drained();
        write_register(skf_pkg::REG_PNOISE, 32'd0);
        write_register(skf_pkg::REG_MNOISE, 32'd0);
        send_measurement(S_MAX);
        send_measurement(S_MIN);
        send_measurement(32'h1234_5678);

        // reload at the negative end, then huge q saturates the covariance
        wait_drained();
        write_register(skf_pkg::REG_INIT, S_MIN);
        write_register(skf_pkg::REG_PNOISE, 32'hFFFF_FFFF);
        write_register(skf_pkg::REG_MNOISE, 32'hFFFF_FFFF);
        send_measurement(S_MAX);
        send_measurement(S_MAX);
        send_measurement(S_MIN);

        // unused address is ignored, r change alone keeps estimate and covariance
        wait_drained();
        write_register(REG_SPARE, $urandom());
        write_register(skf_pkg::REG_MNOISE, 32'd0);
        send_measurement(32'hFFFF_FFFF);
        send_measurement(32'd1);
        send_measurement(S_MIN);

        // reload at the positive end with the smallest nonzero noises
        wait_drained();
        write_register(skf_pkg::REG_INIT, S_MAX);
        write_register(skf_pkg::REG_PNOISE, 32'd1);
        write_register(skf_pkg::REG_MNOISE, 32'd1);
        send_measurement(S_MIN);
        send_measurement(S_MAX);
        send_measurement(32'd0);

        // random phases, each with its own noise settings and signal level
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            steady = (phase == 3);
            write_register(skf_pkg::REG_PNOISE, pick_noise());
            write_register(skf_pkg::REG_MNOISE, pick_noise());
            if (phase % 2 == 0 || $urandom_range(0, 1) == 1) begin
                write_register(skf_pkg::REG_INIT, pick_start());
            end
            target = $urandom();
            n_items = $urandom_range(90, 116);
            for (int n = 0; n < n_items; n++) begin
                // mid-phase, sender keeps going while the receiver stops
                if (phase == 5 && n == 40) hold_off_req = 1'b1;
                send_measurement(pick_measurement(target));
            end
        end
        steady = 1'b0;

        wait_drained();
        if (tracker.expected_estimates.size() != 0) begin
            $error("estimate: %0d still expected at the end",
                   tracker.expected_estimates.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("scalar_kalman_filter_tb OK");
        end else begin
            $display("scalar_kalman_filter_tb NOT OK");
        end
        $finish;
    end

    // estimate side: check what is taken, then pick next ready
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) tracker.check_estimate(o_estimate);
            if (hold_off_req) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("scalar_kalman_filter_tb NOT OK");
                $finish;
            end
        end
    end

endmodule
